FILE: hw/rtl/cpwm_pkg.sv
// ----------------------------------------------------------------------------
// cpwm_pkg
// Types, widths and the quarter-wave sine table shared by the dq to
// center-aligned PWM pipeline.
// ----------------------------------------------------------------------------
package cpwm_pkg;

   localparam logic [15:0] PERIOD_RESET = 16'd4096;
   localparam int ROM_DEPTH = 256;
   localparam int ROM_AW    = $clog2(ROM_DEPTH);
   localparam logic signed [15:0] SQRT3_HALF_Q15 = 16'sd28378;
   // 3 * 32768 / 2
   localparam logic [15:0] MOD_GAIN = 16'd49152;

   localparam int AB_W   = 17;            // alpha / beta
   localparam int PH_W   = 18;            // phase offsets
   localparam int PROD_W = 33;            // 17 x 16 signed products
   localparam int MX_W   = 17;            // largest phase magnitude
   localparam int SQ_W   = 17;            // scaling quotient bits
   localparam int SN_W   = MX_W + SQ_W;   // scaling remainder
   localparam int MN_W   = 32;            // modulation numerator
   localparam int MQ_W   = 16;            // modulation quotient bits

   typedef enum logic [1:0] {
      QUAD_0 = 2'd0,
      QUAD_1 = 2'd1,
      QUAD_2 = 2'd2,
      QUAD_3 = 2'd3
   } quad_type;

   typedef struct packed {
      logic [15:0]        rotor_angle;
      logic signed [15:0] d_voltage_ref;
      logic signed [15:0] q_voltage_ref;
   } req_word_type;

   typedef struct packed {
      logic [15:0]        phase_a_compare;
      logic [15:0]        phase_b_compare;
      logic [15:0]        phase_c_compare;
      logic signed [15:0] applied_mod_alpha;
      logic signed [15:0] applied_mod_beta;
   } rsp_word_type;

   typedef struct packed {
      logic                   vld;
      logic signed [AB_W-1:0] alpha;
      logic signed [AB_W-1:0] beta;
   } ab_word_type;

   typedef struct packed {
      logic                   vld;
      logic signed [PH_W-1:0] pa;
      logic signed [PH_W-1:0] pb;
      logic signed [PH_W-1:0] pc;
      logic signed [AB_W-1:0] alpha;
      logic signed [AB_W-1:0] beta;
   } ph_word_type;

   typedef struct packed {
      logic                   vld;
      logic signed [PH_W-1:0] pa;
      logic signed [PH_W-1:0] pb;
      logic signed [PH_W-1:0] pc;
      logic signed [15:0]     ma;
      logic signed [15:0]     mb;
   } mod_word_type;

   localparam logic [15:0] SINE_ROM [ROM_DEPTH] = '{
      16'h0000, 16'h00C9, 16'h0192, 16'h025B, 16'h0324, 16'h03ED, 16'h04B6, 16'h057F,
      16'h0648, 16'h0711, 16'h07D9, 16'h08A2, 16'h096B, 16'h0A33, 16'h0AFB, 16'h0BC4,
      16'h0C8C, 16'h0D54, 16'h0E1C, 16'h0EE4, 16'h0FAB, 16'h1073, 16'h113A, 16'h1201,
      16'h12C8, 16'h138F, 16'h1455, 16'h151C, 16'h15E2, 16'h16A8, 16'h176E, 16'h1833,
      16'h18F9, 16'h19BE, 16'h1A83, 16'h1B47, 16'h1C0C, 16'h1CD0, 16'h1D93, 16'h1E57,
      16'h1F1A, 16'h1FDD, 16'h209F, 16'h2162, 16'h2224, 16'h22E5, 16'h23A7, 16'h2467,
      16'h2528, 16'h25E8, 16'h26A8, 16'h2768, 16'h2827, 16'h28E5, 16'h29A4, 16'h2A62,
      16'h2B1F, 16'h2BDC, 16'h2C99, 16'h2D55, 16'h2E11, 16'h2ECC, 16'h2F87, 16'h3042,
      16'h30FC, 16'h31B5, 16'h326E, 16'h3327, 16'h33DF, 16'h3497, 16'h354E, 16'h3604,
      16'h36BA, 16'h3770, 16'h3825, 16'h38D9, 16'h398D, 16'h3A40, 16'h3AF3, 16'h3BA5,
      16'h3C57, 16'h3D08, 16'h3DB8, 16'h3E68, 16'h3F17, 16'h3FC6, 16'h4074, 16'h4121,
      16'h41CE, 16'h427A, 16'h4326, 16'h43D1, 16'h447B, 16'h4524, 16'h45CD, 16'h4675,
      16'h471D, 16'h47C4, 16'h486A, 16'h490F, 16'h49B4, 16'h4A58, 16'h4AFB, 16'h4B9E,
      16'h4C40, 16'h4CE1, 16'h4D81, 16'h4E21, 16'h4EC0, 16'h4F5E, 16'h4FFB, 16'h5098,
      16'h5134, 16'h51CF, 16'h5269, 16'h5303, 16'h539B, 16'h5433, 16'h54CA, 16'h5560,
      16'h55F6, 16'h568A, 16'h571E, 16'h57B1, 16'h5843, 16'h58D4, 16'h5964, 16'h59F4,
      16'h5A82, 16'h5B10, 16'h5B9D, 16'h5C29, 16'h5CB4, 16'h5D3E, 16'h5DC8, 16'h5E50,
      16'h5ED7, 16'h5F5E, 16'h5FE4, 16'h6068, 16'h60EC, 16'h616F, 16'h61F1, 16'h6272,
      16'h62F2, 16'h6371, 16'h63EF, 16'h646C, 16'h64E9, 16'h6564, 16'h65DE, 16'h6657,
      16'h66D0, 16'h6747, 16'h67BD, 16'h6832, 16'h68A7, 16'h691A, 16'h698C, 16'h69FD,
      16'h6A6E, 16'h6ADD, 16'h6B4B, 16'h6BB8, 16'h6C24, 16'h6C8F, 16'h6CF9, 16'h6D62,
      16'h6DCA, 16'h6E31, 16'h6E97, 16'h6EFB, 16'h6F5F, 16'h6FC2, 16'h7023, 16'h7083,
      16'h70E3, 16'h7141, 16'h719E, 16'h71FA, 16'h7255, 16'h72AF, 16'h7308, 16'h735F,
      16'h73B6, 16'h740B, 16'h7460, 16'h74B3, 16'h7505, 16'h7556, 16'h75A6, 16'h75F4,
      16'h7642, 16'h768E, 16'h76D9, 16'h7723, 16'h776C, 16'h77B4, 16'h77FB, 16'h7840,
      16'h7885, 16'h78C8, 16'h790A, 16'h794A, 16'h798A, 16'h79C9, 16'h7A06, 16'h7A42,
      16'h7A7D, 16'h7AB7, 16'h7AEF, 16'h7B27, 16'h7B5D, 16'h7B92, 16'h7BC6, 16'h7BF9,
      16'h7C2A, 16'h7C5A, 16'h7C89, 16'h7CB7, 16'h7CE4, 16'h7D0F, 16'h7D3A, 16'h7D63,
      16'h7D8A, 16'h7DB1, 16'h7DD6, 16'h7DFB, 16'h7E1E, 16'h7E3F, 16'h7E60, 16'h7E7F,
      16'h7E9D, 16'h7EBA, 16'h7ED6, 16'h7EF0, 16'h7F0A, 16'h7F22, 16'h7F38, 16'h7F4E,
      16'h7F62, 16'h7F75, 16'h7F87, 16'h7F98, 16'h7FA7, 16'h7FB5, 16'h7FC2, 16'h7FCE,
      16'h7FD9, 16'h7FE2, 16'h7FEA, 16'h7FF1, 16'h7FF6, 16'h7FFA, 16'h7FFE, 16'h7FFF
   };

endpackage

FILE: hw/rtl/cpwm_park.sv
// ----------------------------------------------------------------------------
// cpwm_park
// Sine/cosine table lookup and inverse Park transform, three stages.
// ----------------------------------------------------------------------------
module cpwm_park (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   en,
   input  logic                   in_vld,
   input  cpwm_pkg::req_word_type in_word,
   output cpwm_pkg::ab_word_type  ab_word
);

   logic                                 s1_vld_ff, s2_vld_ff, s3_vld_ff;
   logic signed [cpwm_pkg::AB_W-1:0]     sn_ff, cs_ff, sn_in, cs_in;
   logic signed [15:0]                   d1_ff, q1_ff;
   logic signed [cpwm_pkg::PROD_W-1:0]   dcs_ff, qsn_ff, dsn_ff, qcs_ff;
   logic signed [cpwm_pkg::AB_W-1:0]     alpha_ff, beta_ff, alpha_in, beta_in;
   logic [cpwm_pkg::ROM_AW-1:0]          pos, mir;
   logic signed [cpwm_pkg::AB_W-1:0]     rom_p, rom_m;
   cpwm_pkg::quad_type                   quad;
   logic signed [cpwm_pkg::PROD_W:0]     sum_a, sum_b, sh_a, sh_b;

   always_comb begin
      pos   = in_word.rotor_angle[13:6];
      mir   = ~pos;
      quad  = cpwm_pkg::quad_type'(in_word.rotor_angle[15:14]);
      rom_p = $signed({1'b0, cpwm_pkg::SINE_ROM[pos]});
      rom_m = $signed({1'b0, cpwm_pkg::SINE_ROM[mir]});
      case (quad)
         cpwm_pkg::QUAD_0: begin
            sn_in = rom_p;
            cs_in = rom_m;
         end
         cpwm_pkg::QUAD_1: begin
            sn_in = rom_m;
            cs_in = -rom_p;
         end
         cpwm_pkg::QUAD_2: begin
            sn_in = -rom_p;
            cs_in = -rom_m;
         end
         default: begin
            sn_in = -rom_m;
            cs_in = rom_p;
         end
      endcase
   end

   always_comb begin
      sum_a    = (cpwm_pkg::PROD_W+1)'(dcs_ff) - (cpwm_pkg::PROD_W+1)'(qsn_ff);
      sum_b    = (cpwm_pkg::PROD_W+1)'(dsn_ff) + (cpwm_pkg::PROD_W+1)'(qcs_ff);
      sh_a     = sum_a >>> 15;
      sh_b     = sum_b >>> 15;
      // wrap to 16 bits
      alpha_in = cpwm_pkg::AB_W'($signed(sh_a[15:0]));
      beta_in  = cpwm_pkg::AB_W'($signed(sh_b[15:0]));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff <= 1'b0;
         s2_vld_ff <= 1'b0;
         s3_vld_ff <= 1'b0;
      end else if (en) begin
         s1_vld_ff <= in_vld;
         s2_vld_ff <= s1_vld_ff;
         s3_vld_ff <= s2_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         sn_ff    <= sn_in;
         cs_ff    <= cs_in;
         d1_ff    <= in_word.d_voltage_ref;
         q1_ff    <= in_word.q_voltage_ref;
         dcs_ff   <= d1_ff * cs_ff;
         qsn_ff   <= q1_ff * sn_ff;
         dsn_ff   <= d1_ff * sn_ff;
         qcs_ff   <= q1_ff * cs_ff;
         alpha_ff <= alpha_in;
         beta_ff  <= beta_in;
      end
   end

   assign ab_word = '{vld: s3_vld_ff, alpha: alpha_ff, beta: beta_ff};

endmodule

FILE: hw/rtl/cpwm_clarke.sv
// ----------------------------------------------------------------------------
// cpwm_clarke
// Inverse Clarke transform: alpha/beta to three phase offsets, two stages.
// ----------------------------------------------------------------------------
module cpwm_clarke (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  en,
   input  cpwm_pkg::ab_word_type ab_word,
   output cpwm_pkg::ph_word_type ph_word
);

   logic                               s1_vld_ff, s2_vld_ff;
   logic signed [cpwm_pkg::PROD_W-1:0] prod_ff, prod_sh;
   logic signed [cpwm_pkg::AB_W-1:0]   half_ff, half_in, adj;
   logic signed [cpwm_pkg::AB_W-1:0]   a1_ff, b1_ff, a2_ff, b2_ff;
   logic signed [cpwm_pkg::PH_W-1:0]   pa_ff, pb_ff, pc_ff, bp;

   always_comb begin
      // truncate toward zero
      adj     = ab_word.alpha
                + $signed({{(cpwm_pkg::AB_W-1){1'b0}}, ab_word.alpha[cpwm_pkg::AB_W-1]});
      half_in = adj >>> 1;
      prod_sh = prod_ff >>> 15;
      bp      = prod_sh[cpwm_pkg::PH_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff <= 1'b0;
         s2_vld_ff <= 1'b0;
      end else if (en) begin
         s1_vld_ff <= ab_word.vld;
         s2_vld_ff <= s1_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         prod_ff <= ab_word.beta * cpwm_pkg::SQRT3_HALF_Q15;
         half_ff <= half_in;
         a1_ff   <= ab_word.alpha;
         b1_ff   <= ab_word.beta;
         pa_ff   <= cpwm_pkg::PH_W'(a1_ff);
         pb_ff   <= bp - cpwm_pkg::PH_W'(half_ff);
         pc_ff   <= -cpwm_pkg::PH_W'(half_ff) - bp;
         a2_ff   <= a1_ff;
         b2_ff   <= b1_ff;
      end
   end

   assign ph_word = '{vld: s2_vld_ff, pa: pa_ff, pb: pb_ff, pc: pc_ff,
                      alpha: a2_ff, beta: b2_ff};

endmodule

FILE: hw/rtl/cpwm_scale.sv
// ----------------------------------------------------------------------------
// cpwm_scale
// Overmodulation limit: finds the largest phase magnitude and, when it
// exceeds center, scales alpha and beta by center / max through a
// bit-per-stage restoring divider.
// ----------------------------------------------------------------------------
module cpwm_scale (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  en,
   input  logic [15:0]           carrier_period,
   input  cpwm_pkg::ph_word_type ph_word,
   output cpwm_pkg::ab_word_type ab_word
);

   typedef struct packed {
      logic                             vld;
      logic                             scl;
      logic [cpwm_pkg::MX_W-1:0]        mx;
      logic signed [cpwm_pkg::AB_W-1:0] alpha;
      logic signed [cpwm_pkg::AB_W-1:0] beta;
   } smax_type;

   typedef struct packed {
      logic                             vld;
      logic                             scl;
      logic                             neg_a;
      logic                             neg_b;
      logic [cpwm_pkg::MX_W-1:0]        mx;
      logic [cpwm_pkg::SN_W-1:0]        rem_a;
      logic [cpwm_pkg::SN_W-1:0]        rem_b;
      logic [cpwm_pkg::SQ_W-1:0]        q_a;
      logic [cpwm_pkg::SQ_W-1:0]        q_b;
      logic signed [cpwm_pkg::AB_W-1:0] alpha;
      logic signed [cpwm_pkg::AB_W-1:0] beta;
   } sdiv_type;

   smax_type                          m_ff, m_in;
   sdiv_type                          st_ff [cpwm_pkg::SQ_W+1];
   sdiv_type                          st_in [cpwm_pkg::SQ_W+1];
   logic [14:0]                       center;
   logic signed [cpwm_pkg::PH_W-1:0]  na, nb, nc;
   logic [cpwm_pkg::MX_W-1:0]         ma, mb, mc, mab;
   logic [cpwm_pkg::AB_W-1:0]         abs_a, abs_b;
   logic signed [cpwm_pkg::SQ_W:0]    qs_a, qs_b;

   assign center = carrier_period[15:1];

   always_comb begin
      na  = ph_word.pa[cpwm_pkg::PH_W-1] ? -ph_word.pa : ph_word.pa;
      nb  = ph_word.pb[cpwm_pkg::PH_W-1] ? -ph_word.pb : ph_word.pb;
      nc  = ph_word.pc[cpwm_pkg::PH_W-1] ? -ph_word.pc : ph_word.pc;
      ma  = na[cpwm_pkg::MX_W-1:0];
      mb  = nb[cpwm_pkg::MX_W-1:0];
      mc  = nc[cpwm_pkg::MX_W-1:0];
      mab = (mb > ma) ? mb : ma;
      m_in.vld   = ph_word.vld;
      m_in.mx    = (mc > mab) ? mc : mab;
      m_in.scl   = m_in.mx > cpwm_pkg::MX_W'(center);
      m_in.alpha = ph_word.alpha;
      m_in.beta  = ph_word.beta;
   end

   always_comb begin
      logic [cpwm_pkg::SN_W-1:0] dv;
      dv = '0;
      abs_a = m_ff.alpha[cpwm_pkg::AB_W-1] ? -m_ff.alpha : m_ff.alpha;
      abs_b = m_ff.beta[cpwm_pkg::AB_W-1] ? -m_ff.beta : m_ff.beta;
      st_in[0].vld   = m_ff.vld;
      st_in[0].scl   = m_ff.scl;
      st_in[0].neg_a = m_ff.alpha[cpwm_pkg::AB_W-1];
      st_in[0].neg_b = m_ff.beta[cpwm_pkg::AB_W-1];
      st_in[0].mx    = m_ff.mx;
      st_in[0].rem_a = cpwm_pkg::SN_W'(abs_a) * cpwm_pkg::SN_W'(center);
      st_in[0].rem_b = cpwm_pkg::SN_W'(abs_b) * cpwm_pkg::SN_W'(center);
      st_in[0].q_a   = '0;
      st_in[0].q_b   = '0;
      st_in[0].alpha = m_ff.alpha;
      st_in[0].beta  = m_ff.beta;
      for (int k = 0; k < cpwm_pkg::SQ_W; k++) begin
         st_in[k+1] = st_ff[k];
         dv = cpwm_pkg::SN_W'(st_ff[k].mx) << (cpwm_pkg::SQ_W - 1 - k);
         if (st_ff[k].rem_a >= dv) begin
            st_in[k+1].rem_a = st_ff[k].rem_a - dv;
            st_in[k+1].q_a[cpwm_pkg::SQ_W-1-k] = 1'b1;
         end
         if (st_ff[k].rem_b >= dv) begin
            st_in[k+1].rem_b = st_ff[k].rem_b - dv;
            st_in[k+1].q_b[cpwm_pkg::SQ_W-1-k] = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         m_ff.vld <= 1'b0;
         for (int k = 0; k <= cpwm_pkg::SQ_W; k++) begin
            st_ff[k].vld <= 1'b0;
         end
      end else if (en) begin
         m_ff <= m_in;
         for (int k = 0; k <= cpwm_pkg::SQ_W; k++) begin
            st_ff[k] <= st_in[k];
         end
      end
   end

   always_comb begin
      qs_a = st_ff[cpwm_pkg::SQ_W].neg_a ? -$signed({1'b0, st_ff[cpwm_pkg::SQ_W].q_a})
                                         : $signed({1'b0, st_ff[cpwm_pkg::SQ_W].q_a});
      qs_b = st_ff[cpwm_pkg::SQ_W].neg_b ? -$signed({1'b0, st_ff[cpwm_pkg::SQ_W].q_b})
                                         : $signed({1'b0, st_ff[cpwm_pkg::SQ_W].q_b});
      ab_word.vld   = st_ff[cpwm_pkg::SQ_W].vld;
      ab_word.alpha = st_ff[cpwm_pkg::SQ_W].scl ? qs_a[cpwm_pkg::AB_W-1:0]
                                                : st_ff[cpwm_pkg::SQ_W].alpha;
      ab_word.beta  = st_ff[cpwm_pkg::SQ_W].scl ? qs_b[cpwm_pkg::AB_W-1:0]
                                                : st_ff[cpwm_pkg::SQ_W].beta;
   end

endmodule

FILE: hw/rtl/cpwm_modq.sv
// ----------------------------------------------------------------------------
// cpwm_modq
// Applied modulation: alpha/beta times 49152 / period, truncated and
// saturated to Q15, through a bit-per-stage restoring divider.
// ----------------------------------------------------------------------------
module cpwm_modq (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   en,
   input  logic [15:0]            carrier_period,
   input  cpwm_pkg::ph_word_type  ph_word,
   output cpwm_pkg::mod_word_type mod_word
);

   typedef struct packed {
      logic                             vld;
      logic                             neg_a;
      logic                             neg_b;
      logic [cpwm_pkg::MN_W-1:0]        num_a;
      logic [cpwm_pkg::MN_W-1:0]        num_b;
      logic signed [cpwm_pkg::PH_W-1:0] pa;
      logic signed [cpwm_pkg::PH_W-1:0] pb;
      logic signed [cpwm_pkg::PH_W-1:0] pc;
   } mnum_type;

   typedef struct packed {
      logic                             vld;
      logic                             neg_a;
      logic                             neg_b;
      logic                             ovf_a;
      logic                             ovf_b;
      logic [cpwm_pkg::MN_W-1:0]        rem_a;
      logic [cpwm_pkg::MN_W-1:0]        rem_b;
      logic [cpwm_pkg::MQ_W-1:0]        q_a;
      logic [cpwm_pkg::MQ_W-1:0]        q_b;
      logic signed [cpwm_pkg::PH_W-1:0] pa;
      logic signed [cpwm_pkg::PH_W-1:0] pb;
      logic signed [cpwm_pkg::PH_W-1:0] pc;
   } mdiv_type;

   mnum_type                  n_ff, n_in;
   mdiv_type                  st_ff [cpwm_pkg::MQ_W+1];
   mdiv_type                  st_in [cpwm_pkg::MQ_W+1];
   logic [cpwm_pkg::AB_W-1:0] abs_a, abs_b;
   logic [cpwm_pkg::MN_W-1:0] den_top;
   logic signed [15:0]        sat_a, sat_b;

   assign den_top = {carrier_period, {cpwm_pkg::MQ_W{1'b0}}};

   always_comb begin
      abs_a = ph_word.alpha[cpwm_pkg::AB_W-1] ? -ph_word.alpha : ph_word.alpha;
      abs_b = ph_word.beta[cpwm_pkg::AB_W-1] ? -ph_word.beta : ph_word.beta;
      n_in.vld   = ph_word.vld;
      n_in.neg_a = ph_word.alpha[cpwm_pkg::AB_W-1];
      n_in.neg_b = ph_word.beta[cpwm_pkg::AB_W-1];
      n_in.num_a = cpwm_pkg::MN_W'(abs_a) * cpwm_pkg::MN_W'(cpwm_pkg::MOD_GAIN);
      n_in.num_b = cpwm_pkg::MN_W'(abs_b) * cpwm_pkg::MN_W'(cpwm_pkg::MOD_GAIN);
      n_in.pa    = ph_word.pa;
      n_in.pb    = ph_word.pb;
      n_in.pc    = ph_word.pc;
   end

   always_comb begin
      logic [cpwm_pkg::MN_W-1:0] dv;
      dv = '0;
      st_in[0].vld   = n_ff.vld;
      st_in[0].neg_a = n_ff.neg_a;
      st_in[0].neg_b = n_ff.neg_b;
      st_in[0].ovf_a = n_ff.num_a >= den_top;
      st_in[0].ovf_b = n_ff.num_b >= den_top;
      st_in[0].rem_a = n_ff.num_a;
      st_in[0].rem_b = n_ff.num_b;
      st_in[0].q_a   = '0;
      st_in[0].q_b   = '0;
      st_in[0].pa    = n_ff.pa;
      st_in[0].pb    = n_ff.pb;
      st_in[0].pc    = n_ff.pc;
      for (int k = 0; k < cpwm_pkg::MQ_W; k++) begin
         st_in[k+1] = st_ff[k];
         dv = cpwm_pkg::MN_W'(carrier_period) << (cpwm_pkg::MQ_W - 1 - k);
         if (st_ff[k].rem_a >= dv) begin
            st_in[k+1].rem_a = st_ff[k].rem_a - dv;
            st_in[k+1].q_a[cpwm_pkg::MQ_W-1-k] = 1'b1;
         end
         if (st_ff[k].rem_b >= dv) begin
            st_in[k+1].rem_b = st_ff[k].rem_b - dv;
            st_in[k+1].q_b[cpwm_pkg::MQ_W-1-k] = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         n_ff.vld <= 1'b0;
         for (int k = 0; k <= cpwm_pkg::MQ_W; k++) begin
            st_ff[k].vld <= 1'b0;
         end
      end else if (en) begin
         n_ff <= n_in;
         for (int k = 0; k <= cpwm_pkg::MQ_W; k++) begin
            st_ff[k] <= st_in[k];
         end
      end
   end

   always_comb begin
      if (carrier_period == '0) begin
         sat_a = '0;
      end else if (st_ff[cpwm_pkg::MQ_W].neg_a) begin
         if (st_ff[cpwm_pkg::MQ_W].ovf_a || st_ff[cpwm_pkg::MQ_W].q_a > 16'd32768) begin
            sat_a = 16'sh8000;
         end else begin
            sat_a = -$signed(st_ff[cpwm_pkg::MQ_W].q_a);
         end
      end else if (st_ff[cpwm_pkg::MQ_W].ovf_a || st_ff[cpwm_pkg::MQ_W].q_a > 16'd32767) begin
         sat_a = 16'sh7FFF;
      end else begin
         sat_a = $signed(st_ff[cpwm_pkg::MQ_W].q_a);
      end

      if (carrier_period == '0) begin
         sat_b = '0;
      end else if (st_ff[cpwm_pkg::MQ_W].neg_b) begin
         if (st_ff[cpwm_pkg::MQ_W].ovf_b || st_ff[cpwm_pkg::MQ_W].q_b > 16'd32768) begin
            sat_b = 16'sh8000;
         end else begin
            sat_b = -$signed(st_ff[cpwm_pkg::MQ_W].q_b);
         end
      end else if (st_ff[cpwm_pkg::MQ_W].ovf_b || st_ff[cpwm_pkg::MQ_W].q_b > 16'd32767) begin
         sat_b = 16'sh7FFF;
      end else begin
         sat_b = $signed(st_ff[cpwm_pkg::MQ_W].q_b);
      end

      mod_word.vld = st_ff[cpwm_pkg::MQ_W].vld;
      mod_word.pa  = st_ff[cpwm_pkg::MQ_W].pa;
      mod_word.pb  = st_ff[cpwm_pkg::MQ_W].pb;
      mod_word.pc  = st_ff[cpwm_pkg::MQ_W].pc;
      mod_word.ma  = sat_a;
      mod_word.mb  = sat_b;
   end

endmodule

FILE: hw/rtl/dq_to_center_aligned_pwm.sv
// ----------------------------------------------------------------------------
// dq_to_center_aligned_pwm
// Inverse Park / inverse Clarke modulator giving three center-aligned PWM
// compare values and the applied alpha/beta modulation.
// ----------------------------------------------------------------------------
// Fully pipelined: while the result side does not stall, one word per clock
// is accepted and one result word per clock is delivered. A word passes 45
// register stages, most of them in the two bit-per-stage dividers (17 stages
// for the overmodulation scale, 16 for the modulation output), before its
// result shows on rsp_valid. A stall on the result side while rsp_valid is
// high holds the whole pipeline; req_stall follows it in the same cycle.
// The carrier period may only be written while the pipeline is empty.
// ----------------------------------------------------------------------------
module dq_to_center_aligned_pwm (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  cpwm_pkg::req_word_type req_word,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output cpwm_pkg::rsp_word_type rsp_word,
   input  logic                   csr_wr_en,
   input  logic [15:0]            csr_wr_data
);

   logic                   en;
   logic [15:0]            period_ff;
   logic [15:0]            center;
   cpwm_pkg::ab_word_type  park_ab, scale_ab;
   cpwm_pkg::ph_word_type  ph1, ph2;
   cpwm_pkg::mod_word_type mod_w;
   logic                   rsp_valid_ff;
   cpwm_pkg::rsp_word_type rsp_word_ff, rsp_word_in;

   assign en        = !rsp_valid_ff || !rsp_stall;
   assign req_stall = !en;
   assign center    = {1'b0, period_ff[15:1]};

   always_ff @(posedge clock) begin
      if (reset) begin
         period_ff <= cpwm_pkg::PERIOD_RESET;
      end else if (csr_wr_en) begin
         period_ff <= csr_wr_data;
      end
   end

   cpwm_park u_park (
      .clock   (clock),
      .reset   (reset),
      .en      (en),
      .in_vld  (req_valid),
      .in_word (req_word),
      .ab_word (park_ab)
   );

   cpwm_clarke u_clarke_raw (
      .clock   (clock),
      .reset   (reset),
      .en      (en),
      .ab_word (park_ab),
      .ph_word (ph1)
   );

   cpwm_scale u_scale (
      .clock          (clock),
      .reset          (reset),
      .en             (en),
      .carrier_period (period_ff),
      .ph_word        (ph1),
      .ab_word        (scale_ab)
   );

   cpwm_clarke u_clarke_out (
      .clock   (clock),
      .reset   (reset),
      .en      (en),
      .ab_word (scale_ab),
      .ph_word (ph2)
   );

   cpwm_modq u_modq (
      .clock          (clock),
      .reset          (reset),
      .en             (en),
      .carrier_period (period_ff),
      .ph_word        (ph2),
      .mod_word       (mod_w)
   );

   function automatic logic [15:0] clamp_cmp(input logic [15:0] ctr,
                                             input logic [15:0] per,
                                             input logic signed [cpwm_pkg::PH_W-1:0] ph);
      logic signed [cpwm_pkg::PH_W:0] v;
      v = $signed({{(cpwm_pkg::PH_W-14){1'b0}}, ctr[14:0]}) + (cpwm_pkg::PH_W+1)'(ph);
      if (v < 0) begin
         return '0;
      end else if (v > $signed({{(cpwm_pkg::PH_W-15){1'b0}}, per})) begin
         return per;
      end else begin
         return v[15:0];
      end
   endfunction

   always_comb begin
      rsp_word_in.phase_a_compare   = clamp_cmp(center, period_ff, mod_w.pa);
      rsp_word_in.phase_b_compare   = clamp_cmp(center, period_ff, mod_w.pb);
      rsp_word_in.phase_c_compare   = clamp_cmp(center, period_ff, mod_w.pc);
      rsp_word_in.applied_mod_alpha = mod_w.ma;
      rsp_word_in.applied_mod_beta  = mod_w.mb;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         rsp_valid_ff <= mod_w.vld;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rsp_word_ff <= rsp_word_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_word_ff;

endmodule
